// File: rtl/core/spq_pkg.sv
// Shared types, sizes and status codes of the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [15:0] proc_id;
        logic signed [15:0] prio;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] out_id;
        logic signed [15:0] out_prio;
        logic [4:0]         occupancy;
    } rsp_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/sorted_priority_queue.sv
// The insert time is set by the back-to-front walk, one stored entry per cycle on one RAM read port.
// An insert into an empty queue, a full insert or an empty remove goes straight from idle to the finish state.
// One item is in work at a time; the next transfer is taken once the result is registered.
// Reset (rst_n low, asynchronous) empties the queue; the entry RAM needs no clearing.
`timescale 1ns / 1ps

module sorted_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [spq_pkg::IDX_W-1:0] head_reg, head_next;
    logic [spq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [spq_pkg::CNT_W-1:0] k_reg, k_next;
    spq_pkg::req_t             cur_reg, cur_next;
    spq_pkg::rsp_t             res_reg, res_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    spq_pkg::rsp_t             rsp_data_reg, rsp_data_next;

    logic                      ram_we;
    logic [spq_pkg::IDX_W-1:0] ram_waddr;
    spq_pkg::entry_t           ram_wdata;
    logic [spq_pkg::IDX_W-1:0] ram_raddr;
    logic [spq_pkg::ENTRY_W-1:0] ram_rdata;
    spq_pkg::entry_t           rd_entry;

    logic [spq_pkg::CNT_W-1:0] count_inc, count_dec, k_dec, k_dec2;
    logic                      keep_shifting;

    function automatic logic [spq_pkg::IDX_W-1:0] phys(
        input logic [spq_pkg::IDX_W-1:0] base,
        input logic [spq_pkg::IDX_W-1:0] offset
    );
        logic [spq_pkg::IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (spq_pkg::IDX_W + 1)'(spq_pkg::CAPACITY))
        begin
            sum = sum - (spq_pkg::IDX_W + 1)'(spq_pkg::CAPACITY);
        end
        return sum[spq_pkg::IDX_W-1:0];
    endfunction

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (spq_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign count_inc = count_reg + spq_pkg::CNT_W'(1);
    assign count_dec = count_reg - spq_pkg::CNT_W'(1);
    assign k_dec     = k_reg - spq_pkg::CNT_W'(1);
    assign k_dec2    = k_reg - spq_pkg::CNT_W'(2);
    assign keep_shifting = $signed(rd_entry.prio) >= cur_reg.prio;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = '{id: cur_reg.proc_id, prio: cur_reg.prio};
        ram_raddr      = head_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next = req_data;
                    res_next = '0;
                    if (req_data.op == spq_pkg::OP_INSERT)
                    begin
                        if (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY))
                        begin
                            res_next.status    = spq_pkg::ST_FULL;
                            res_next.occupancy = 5'(count_reg);
                            state_next         = S_FIN;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = head_reg;
                            ram_wdata          = '{id: req_data.proc_id, prio: req_data.prio};
                            count_next         = count_inc;
                            res_next.status    = spq_pkg::ST_INSERTED;
                            res_next.occupancy = 5'(count_inc);
                            state_next         = S_FIN;
                        end
                        else
                        begin
                            k_next     = count_reg;
                            ram_raddr  = phys(head_reg, count_dec[spq_pkg::IDX_W-1:0]);
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status    = spq_pkg::ST_EMPTY;
                            res_next.occupancy = 5'(count_reg);
                            state_next         = S_FIN;
                        end
                        else
                        begin
                            ram_raddr  = head_reg;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, k_reg[spq_pkg::IDX_W-1:0]);
                if (keep_shifting)
                begin
                    ram_wdata = rd_entry;
                    k_next    = k_dec;
                    if (k_dec == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ram_raddr = phys(head_reg, k_dec2[spq_pkg::IDX_W-1:0]);
                    end
                end
                else
                begin
                    count_next         = count_inc;
                    res_next.status    = spq_pkg::ST_INSERTED;
                    res_next.occupancy = 5'(count_inc);
                    state_next         = S_FIN;
                end
            end

            S_PLACE:
            begin
                ram_we             = 1'b1;
                ram_waddr          = head_reg;
                count_next         = count_inc;
                res_next.status    = spq_pkg::ST_INSERTED;
                res_next.occupancy = 5'(count_inc);
                state_next         = S_FIN;
            end

            S_POP:
            begin
                res_next.status    = spq_pkg::ST_REMOVED;
                res_next.out_id    = rd_entry.id;
                res_next.out_prio  = rd_entry.prio;
                res_next.occupancy = 5'(count_dec);
                head_next          = phys(head_reg, spq_pkg::IDX_W'(1));
                count_next         = count_dec;
                state_next         = S_FIN;
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// File: rtl/core/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/spq_checker.sv
// Port-level assertions for the sorted priority queue and their binding.
`timescale 1ns / 1ps

module spq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input spq_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spq_pkg::rsp_t rsp_data
);

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("Response valid dropped while stalled.");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_data))
        else $error("Response payload changed while stalled.");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status != spq_pkg::ST_EMPTY || rsp_data.occupancy == 5'd0))
        else $error("Empty status reported with a nonzero occupancy.");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status != spq_pkg::ST_FULL
                       || rsp_data.occupancy == 5'(spq_pkg::CAPACITY)))
        else $error("Full status reported below capacity.");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == spq_pkg::ST_REMOVED
                       || (rsp_data.out_id == '0 && rsp_data.out_prio == '0)))
        else $error("Entry fields are nonzero on a transfer that removed nothing.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

// File: test/spq_queue_checker.sv
// Checker that predicts every queue response from the request transfers and compares it.
`timescale 1ns / 1ps

module spq_queue_checker
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   failures,
    output int   outstanding,
    output int   checked,
    output int   full_drops,
    output int   empty_pops
);

    logic signed [15:0] held_id   [0:CAPACITY-1];
    logic signed [15:0] held_prio [0:CAPACITY-1];
    int                 held;

    rsp_t op_outcomes [$];
    rsp_t owed;
    rsp_t outcome;
    int   err_count;
    int   n_checked;
    int   n_full;
    int   n_empty;
    bit   bad;

    task automatic apply_queue_op(input req_t r, output rsp_t res);
        int pos;
        int i;
        begin
            res = '0;
            if (r.op == OP_INSERT)
            begin
                if (held >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held && held_prio[pos] < $signed(r.prio))
                        pos++;
                    for (i = held; i > pos; i--)
                    begin
                        held_id[i]   = held_id[i-1];
                        held_prio[i] = held_prio[i-1];
                    end
                    held_id[pos]   = r.proc_id;
                    held_prio[pos] = r.prio;
                    held++;
                    res.status = ST_INSERTED;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.out_id   = held_id[0];
                    res.out_prio = held_prio[0];
                    for (i = 1; i < held; i++)
                    begin
                        held_id[i-1]   = held_id[i];
                        held_prio[i-1] = held_prio[i];
                    end
                    held--;
                    res.status = ST_REMOVED;
                end
            end
            res.occupancy = 5'(held);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            op_outcomes.delete();
            err_count = 0;
            n_checked = 0;
            n_full = 0;
            n_empty = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (op_outcomes.size() == 0)
                begin
                    $display("%0t: response with none pending: status %0d id %0d prio %0d occ %0d",
                             $time, rsp_data.status, rsp_data.out_id, rsp_data.out_prio,
                             rsp_data.occupancy);
                    err_count++;
                end
                else
                begin
                    owed = op_outcomes.pop_front();
                    bad = 1'b0;
                    if (rsp_data.status !== owed.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, owed.status, rsp_data.status);
                        bad = 1'b1;
                    end
                    if (rsp_data.out_id !== owed.out_id)
                    begin
                        $display("%0t: out_id expected %0d, got %0d",
                                 $time, owed.out_id, rsp_data.out_id);
                        bad = 1'b1;
                    end
                    if (rsp_data.out_prio !== owed.out_prio)
                    begin
                        $display("%0t: out_prio expected %0d, got %0d",
                                 $time, owed.out_prio, rsp_data.out_prio);
                        bad = 1'b1;
                    end
                    if (rsp_data.occupancy !== owed.occupancy)
                    begin
                        $display("%0t: occupancy expected %0d, got %0d",
                                 $time, owed.occupancy, rsp_data.occupancy);
                        bad = 1'b1;
                    end
                    if (bad)
                        err_count++;
                    n_checked++;
                    if (owed.status == ST_FULL)
                        n_full++;
                    if (owed.status == ST_EMPTY)
                        n_empty++;
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_queue_op(req_data, outcome);
                op_outcomes.push_back(outcome);
            end
        end
        failures    <= err_count;
        outstanding <= op_outcomes.size();
        checked     <= n_checked;
        full_drops  <= n_full;
        empty_pops  <= n_empty;
    end

endmodule

// File: test/sorted_priority_queue_tb.sv
// Top of the sorted priority queue testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    int failures;
    int outstanding;
    int checked;
    int full_drops;
    int empty_pops;
    int issued;
    int quiet;
    bit steady_flow;
    bit hold_request;

    sorted_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    spq_queue_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_data    (rsp_data),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked),
        .full_drops  (full_drops),
        .empty_pops  (empty_pops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_break();
        return !steady_flow && ($urandom_range(99) < 33);
    endfunction

    function automatic logic [15:0] pick_priority();
        case ($urandom_range(3))
            0: return 16'($urandom_range(6)) - 16'd3;
            1: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7FFF;
                   2: return 16'h0000;
                   default: return 16'hFFFF;
               endcase
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic offer_request(input logic op, input logic [15:0] id,
                                 input logic [15:0] prio);
        req_t r;
        begin
            r.op = op;
            r.proc_id = id;
            r.prio = prio;
            if (take_break())
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (take_break())
                    @(posedge clk);
            end
            req_valid <= 1'b1;
            req_data  <= r;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            issued++;
        end
    endtask

    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                rsp_stall <= take_break();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        int insert_pct;
        logic op;

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_data <= '0;
        issued = 0;
        steady_flow = 1'b0;
        hold_request = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // An empty remove, a fill with extreme and tied priorities, two dropped inserts, then five removes.
        offer_request(OP_REMOVE, 16'h7FFF, 16'h8000);
        offer_request(OP_INSERT, 16'h8000, 16'h0000);
        offer_request(OP_INSERT, 16'h7FFF, 16'h7FFF);
        offer_request(OP_INSERT, 16'h0000, 16'h8000);
        offer_request(OP_INSERT, 16'hFFFF, 16'hFFFF);
        offer_request(OP_INSERT, 16'h0001, 16'h0000);
        offer_request(OP_INSERT, 16'h0002, 16'h8000);
        offer_request(OP_INSERT, 16'h0003, 16'h7FFF);
        offer_request(OP_INSERT, 16'h0004, 16'h0001);
        for (n = 0; n < 8; n++)
            offer_request(OP_INSERT, 16'($urandom), pick_priority());
        offer_request(OP_INSERT, 16'h1234, 16'h8000);
        offer_request(OP_INSERT, 16'h5555, 16'h7FFF);
        for (n = 0; n < 5; n++)
            offer_request(OP_REMOVE, 16'($urandom), 16'($urandom));

        // Alternate filling and draining runs so that full and empty are both reached often.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            insert_pct = ((n / 40) % 2 == 0) ? 75 : 30;
            steady_flow = (n >= 500 && n < 800);
            if (n == 300)
                hold_request = 1'b1;
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            offer_request(op, 16'($urandom), pick_priority());
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d request transfers and %0d checked responses.",
                 issued, checked);
        $display("Inserts dropped on a full queue: %0d; removes on an empty queue: %0d.",
                 full_drops, empty_pops);
        if (failures == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
